FILE: src/adbp_pkg.sv
`default_nettype none

package adbp_pkg;

    localparam int MAX_CHANNELS_DEF = 4;
    localparam int FRAME_LIMIT_DEF  = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS_IN_USE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_SHIFT         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEFF_R           = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_PACKET = 2'd3;

    localparam logic [2:0]  RST_CHANNELS_IN_USE   = 3'd2;
    localparam logic [4:0]  RST_PAD_SHIFT         = 5'd0;
    localparam logic [14:0] RST_COEFF_R           = 15'd31482;
    localparam logic [10:0] RST_FRAMES_PER_PACKET = 11'd256;

    localparam logic [14:0] R_FLOOR       = 15'd30000;
    localparam logic [4:0]  DEFAULT_SHIFT = 5'd8;
    localparam int          Q15_SHIFT     = 15;
    localparam logic signed [15:0] PCM_MAX = 16'sh7fff;
    localparam logic signed [15:0] PCM_MIN = 16'sh8000;

    typedef struct packed {
        logic [2:0]  channels_in_use;
        logic [4:0]  pad_shift;
        logic [14:0] coeff_r;
        logic [10:0] frames_per_packet;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] raw_sample;
        logic               block_end;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pcm_out;
        logic [1:0]         chan_index;
        logic [15:0]        packet_seq;
        logic [9:0]         frame_index;
        logic               packet_last;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  chan_index;
        logic [15:0] packet_seq;
        logic [9:0]  frame_index;
        logic        packet_last;
    } pkt_pos_t;

endpackage

`default_nettype wire

FILE: src/adbp_filter.sv
`default_nettype none

module adbp_filter #(
    parameter int MAX_CHANNELS = adbp_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              enable,
    input  wire logic [$clog2(MAX_CHANNELS)-1:0]   chan_sel,
    input  wire logic signed [31:0]                raw_sample,
    input  wire adbp_pkg::cfg_t                    cfg,
    output logic signed [15:0]                     pcm_out
);
    import adbp_pkg::*;

    logic [31:0] prev_in_reg  [MAX_CHANNELS];
    logic [31:0] prev_out_reg [MAX_CHANNELS];

    logic [4:0]         shift_amt;
    logic [14:0]        r_eff;
    logic signed [31:0] x_val;
    logic signed [47:0] prod;
    logic [31:0]        scaled;
    logic [31:0]        y_val;

    always_comb
    begin
        shift_amt = (cfg.pad_shift == 5'd0) ? DEFAULT_SHIFT : cfg.pad_shift;
        r_eff     = (cfg.coeff_r < R_FLOOR) ? R_FLOOR : cfg.coeff_r;
        x_val     = raw_sample >>> shift_amt;
        prod      = $signed(prev_out_reg[chan_sel]) * $signed({1'b0, r_eff});
        scaled    = prod[Q15_SHIFT+31:Q15_SHIFT];
        y_val     = x_val - prev_in_reg[chan_sel] + scaled;
        if (!y_val[31] && (y_val[30:15] != 16'h0000))
        begin
            pcm_out = PCM_MAX;
        end
        else if (y_val[31] && (y_val[30:15] != 16'hffff))
        begin
            pcm_out = PCM_MIN;
        end
        else
        begin
            pcm_out = y_val[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CHANNELS; i++)
            begin
                prev_in_reg[i]  <= '0;
                prev_out_reg[i] <= '0;
            end
        end
        else if (enable)
        begin
            prev_in_reg[chan_sel]  <= x_val;
            prev_out_reg[chan_sel] <= y_val;
        end
    end

endmodule

`default_nettype wire

FILE: src/adbp_seq.sv
`default_nettype none

module adbp_seq #(
    parameter int MAX_CHANNELS = adbp_pkg::MAX_CHANNELS_DEF,
    parameter int FRAME_LIMIT  = adbp_pkg::FRAME_LIMIT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              advance,
    input  wire logic                              block_end,
    input  wire adbp_pkg::cfg_t                    cfg,
    output logic [$clog2(MAX_CHANNELS)-1:0]        chan_sel,
    output adbp_pkg::pkt_pos_t                     pos
);
    import adbp_pkg::*;

    localparam int CH_W = $clog2(MAX_CHANNELS);
    localparam int NCW  = (CH_W + 1 > 3) ? CH_W + 1 : 3;
    localparam int FR_W = $clog2(FRAME_LIMIT);
    localparam int FPW  = (FR_W + 1 > 11) ? FR_W + 1 : 11;

    logic [CH_W-1:0] chan_cnt_reg, chan_cnt_next;
    logic [FR_W-1:0] frame_cnt_reg, frame_cnt_next;
    logic [15:0]     seq_cnt_reg, seq_cnt_next;

    logic [NCW-1:0]  nch_raw, nch_eff;
    logic [FPW-1:0]  fpp_raw, fpp_eff;
    logic            frame_end;
    logic            last;
    logic [CH_W+1:0] chan_wide;
    logic [FR_W+9:0] frame_wide;

    always_comb
    begin
        nch_raw = NCW'(cfg.channels_in_use);
        if (nch_raw < NCW'(2))
        begin
            nch_eff = NCW'(2);
        end
        else if (nch_raw > NCW'(MAX_CHANNELS))
        begin
            nch_eff = NCW'(MAX_CHANNELS);
        end
        else
        begin
            nch_eff = nch_raw;
        end

        fpp_raw = FPW'(cfg.frames_per_packet);
        if (fpp_raw < FPW'(1))
        begin
            fpp_eff = FPW'(1);
        end
        else if (fpp_raw > FPW'(FRAME_LIMIT))
        begin
            fpp_eff = FPW'(FRAME_LIMIT);
        end
        else
        begin
            fpp_eff = fpp_raw;
        end

        frame_end = (NCW'(chan_cnt_reg) + NCW'(1)) >= nch_eff;
        last = block_end || (frame_end && ((FPW'(frame_cnt_reg) + FPW'(1)) >= fpp_eff));

        chan_cnt_next  = chan_cnt_reg;
        frame_cnt_next = frame_cnt_reg;
        seq_cnt_next   = seq_cnt_reg;
        if (advance)
        begin
            if (last)
            begin
                chan_cnt_next  = '0;
                frame_cnt_next = '0;
                seq_cnt_next   = seq_cnt_reg + 16'd1;
            end
            else if (frame_end)
            begin
                chan_cnt_next  = '0;
                frame_cnt_next = frame_cnt_reg + FR_W'(1);
            end
            else
            begin
                chan_cnt_next = chan_cnt_reg + CH_W'(1);
            end
        end

        chan_wide  = {2'b00, chan_cnt_reg};
        frame_wide = {10'd0, frame_cnt_reg};

        chan_sel        = chan_cnt_reg;
        pos.chan_index  = chan_wide[1:0];
        pos.packet_seq  = seq_cnt_reg;
        pos.frame_index = frame_wide[9:0];
        pos.packet_last = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cnt_reg  <= '0;
            frame_cnt_reg <= '0;
            seq_cnt_reg   <= '0;
        end
        else
        begin
            chan_cnt_reg  <= chan_cnt_next;
            frame_cnt_reg <= frame_cnt_next;
            seq_cnt_reg   <= seq_cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/audio_dc_block_packetizer.sv
// Channel  Direction  Payload                 Transaction
// in       input      adbp_pkg::in_item_t     in_valid & in_ready
// out      output     adbp_pkg::out_item_t    out_valid & out_ready
// cfg      input      cfg_index, cfg_data     cfg_valid & cfg_ready (always ready)
//
// One sample per cycle sustained while the output is not stalled; out_valid is registered.
// The input register feeds one pass of shift, 32x16 multiply, add and saturation into the
// output register, which also updates the per-channel filter state and the packet counters.
// A stalled output holds the output and input registers; input is still taken when the
// input register is empty or moving forward. Reset sets all but data registers at once.
`default_nettype none

module audio_dc_block_packetizer #(
    parameter int MAX_CHANNELS = adbp_pkg::MAX_CHANNELS_DEF,
    parameter int FRAME_LIMIT  = adbp_pkg::FRAME_LIMIT_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire adbp_pkg::in_item_t                in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output adbp_pkg::out_item_t                    out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [adbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [adbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import adbp_pkg::*;

    localparam int CH_W = $clog2(MAX_CHANNELS);

    cfg_t               cfg_reg, cfg_next;
    logic               s1_valid_reg;
    logic signed [31:0] s1_raw_reg;
    logic               s1_end_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               advance;
    logic [CH_W-1:0]    chan_sel;
    pkt_pos_t           pos;
    logic signed [15:0] pcm;

    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNELS_IN_USE:   cfg_next.channels_in_use   = cfg_data[2:0];
                REG_PAD_SHIFT:         cfg_next.pad_shift         = cfg_data[4:0];
                REG_COEFF_R:           cfg_next.coeff_r           = cfg_data[14:0];
                REG_FRAMES_PER_PACKET: cfg_next.frames_per_packet = cfg_data[10:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channels_in_use   <= RST_CHANNELS_IN_USE;
            cfg_reg.pad_shift         <= RST_PAD_SHIFT;
            cfg_reg.coeff_r           <= RST_COEFF_R;
            cfg_reg.frames_per_packet <= RST_FRAMES_PER_PACKET;
            s1_valid_reg              <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!out_valid_reg || out_ready)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_raw_reg <= in_data.raw_sample;
            s1_end_reg <= in_data.block_end;
        end
        if (advance)
        begin
            out_data_reg.pcm_out     <= pcm;
            out_data_reg.chan_index  <= pos.chan_index;
            out_data_reg.packet_seq  <= pos.packet_seq;
            out_data_reg.frame_index <= pos.frame_index;
            out_data_reg.packet_last <= pos.packet_last;
        end
    end

    adbp_seq #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .FRAME_LIMIT  (FRAME_LIMIT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .block_end (s1_end_reg),
        .cfg       (cfg_reg),
        .chan_sel  (chan_sel),
        .pos       (pos)
    );

    adbp_filter #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (advance),
        .chan_sel   (chan_sel),
        .raw_sample (s1_raw_reg),
        .cfg        (cfg_reg),
        .pcm_out    (pcm)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none

module tb;

    import adbp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD = 300;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_SAMPLES = 85;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    in_item_t sample_q[$];
    out_item_t pcm_expect_q[$];
    reg_write_t reg_write_q[$];
    reg_write_t pending_write;

    cfg_t shadow_cfg = '{RST_CHANNELS_IN_USE, RST_PAD_SHIFT, RST_COEFF_R, RST_FRAMES_PER_PACKET};
    logic signed [31:0] prev_x [4] = '{default: '0};
    logic signed [31:0] prev_y [4] = '{default: '0};
    logic [1:0] chan_cnt = '0;
    logic [9:0] frame_cnt = '0;
    logic [15:0] seq_cnt = '0;

    int samples_pushed = 0;
    int samples_accepted = 0;
    int results_checked = 0;
    int reg_writes_issued = 0;
    int reg_writes_done = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    int burst_left = 1;
    int gap_left = 0;
    int holds_requested = 0;
    int holds_taken = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_span = 0;
    int rx_tick = 0;

    audio_dc_block_packetizer uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic predict_sample(input in_item_t s);
        int nch;
        int fpp;
        int sh;
        int ch;
        logic [14:0] r;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [63:0] prod;
        logic frame_end;
        logic last;
        out_item_t e;
        nch = shadow_cfg.channels_in_use;
        if (nch < 2)
            nch = 2;
        if (nch > MAX_CHANNELS_DEF)
            nch = MAX_CHANNELS_DEF;
        fpp = shadow_cfg.frames_per_packet;
        if (fpp < 1)
            fpp = 1;
        if (fpp > FRAME_LIMIT_DEF)
            fpp = FRAME_LIMIT_DEF;
        r = (shadow_cfg.coeff_r < R_FLOOR) ? R_FLOOR : shadow_cfg.coeff_r;
        sh = (shadow_cfg.pad_shift == '0) ? DEFAULT_SHIFT : shadow_cfg.pad_shift;
        ch = chan_cnt;
        x = $signed(s.raw_sample) >>> sh;
        prod = 64'(prev_y[ch]) * $signed({49'd0, r});
        y = x - prev_x[ch] + prod[Q15_SHIFT+31:Q15_SHIFT];
        prev_x[ch] = x;
        prev_y[ch] = y;
        frame_end = (ch + 1) >= nch;
        last = s.block_end || (frame_end && (int'(frame_cnt) + 1 >= fpp));
        if (y > 32767)
            e.pcm_out = PCM_MAX;
        else if (y < -32768)
            e.pcm_out = PCM_MIN;
        else
            e.pcm_out = y[15:0];
        e.chan_index = chan_cnt;
        e.packet_seq = seq_cnt;
        e.frame_index = frame_cnt;
        e.packet_last = last;
        pcm_expect_q.push_back(e);
        if (last)
        begin
            chan_cnt = '0;
            frame_cnt = '0;
            seq_cnt = seq_cnt + 16'd1;
        end
        else if (frame_end)
        begin
            chan_cnt = '0;
            frame_cnt = frame_cnt + 10'd1;
        end
        else
        begin
            chan_cnt = chan_cnt + 2'd1;
        end
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%s mismatch on result %0d: got %0h, expected %0h",
                 field, results_checked, got, want);
        mismatch_count = mismatch_count + 1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_sample(in_data);
                samples_accepted <= samples_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    in_data <= sample_q.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left <= burst_left - 1;
                    else
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_CHANNELS_IN_USE: shadow_cfg.channels_in_use <= cfg_data[2:0];
                    REG_PAD_SHIFT: shadow_cfg.pad_shift <= cfg_data[4:0];
                    REG_COEFF_R: shadow_cfg.coeff_r <= cfg_data[14:0];
                    REG_FRAMES_PER_PACKET: shadow_cfg.frames_per_packet <= cfg_data[10:0];
                    default: ;
                endcase
                reg_writes_done <= reg_writes_done + 1;
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_write_q.size() > 0)
                begin
                    pending_write = reg_write_q.pop_front();
                    cfg_index <= pending_write.idx;
                    cfg_data <= pending_write.data;
                    cfg_valid <= 1'b1;
                end
                else
                begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // A requested hold keeps the output stalled long enough for the input side to back up.
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (holds_taken < holds_requested)
        begin
            holds_taken <= holds_taken + 1;
            hold_left <= LONG_HOLD;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_span <= $urandom_range(16, 160);
            end
            else
            begin
                stall_span <= stall_span - 1;
            end
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (rx_tick % 3) != 2;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pcm_expect_q.size() == 0)
            begin
                report_mismatch("unexpected transaction", 32'(out_data.pcm_out), '0);
            end
            else
            begin
                out_item_t want;
                want = pcm_expect_q.pop_front();
                if (out_data.pcm_out !== want.pcm_out)
                    report_mismatch("pcm_out", 32'(out_data.pcm_out), 32'(want.pcm_out));
                if (out_data.chan_index !== want.chan_index)
                    report_mismatch("chan_index", 32'(out_data.chan_index),
                                    32'(want.chan_index));
                if (out_data.packet_seq !== want.packet_seq)
                    report_mismatch("packet_seq", 32'(out_data.packet_seq),
                                    32'(want.packet_seq));
                if (out_data.frame_index !== want.frame_index)
                    report_mismatch("frame_index", 32'(out_data.frame_index),
                                    32'(want.frame_index));
                if (out_data.packet_last !== want.packet_last)
                    report_mismatch("packet_last", 32'(out_data.packet_last),
                                    32'(want.packet_last));
                results_checked <= results_checked + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_quiet();
        while (samples_accepted != samples_pushed || results_checked != samples_accepted
               || reg_writes_done != reg_writes_issued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        reg_write_t w;
        wait_quiet();
        w.idx = idx;
        w.data = value[CFG_DATA_W-1:0];
        reg_write_q.push_back(w);
        reg_writes_issued = reg_writes_issued + 1;
        wait_quiet();
    endtask

    task automatic push_sample(input logic [31:0] raw, input logic blk_end);
        in_item_t s;
        s.raw_sample = raw;
        s.block_end = blk_end;
        sample_q.push_back(s);
        samples_pushed = samples_pushed + 1;
    endtask

    initial
    begin
        logic [31:0] dc_level;
        logic [31:0] raw;
        int kind;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        push_sample(32'h7fffffff, 1'b0);
        push_sample(32'h80000000, 1'b0);
        push_sample(32'h00000000, 1'b0);
        push_sample(32'hffffffff, 1'b0);
        push_sample(32'h00000100, 1'b1);
        push_sample(32'h00000001, 1'b0);

        write_reg(REG_CHANNELS_IN_USE, 7);
        write_reg(REG_PAD_SHIFT, 1);
        write_reg(REG_COEFF_R, 0);
        write_reg(REG_FRAMES_PER_PACKET, 0);
        push_sample(32'h7fffffff, 1'b0);
        push_sample(32'h7fffffff, 1'b0);
        push_sample(32'h80000000, 1'b0);
        push_sample(32'h80000000, 1'b0);

        write_reg(REG_CHANNELS_IN_USE, 4);
        write_reg(REG_PAD_SHIFT, 31);
        write_reg(REG_COEFF_R, 32767);
        write_reg(REG_FRAMES_PER_PACKET, 2047);
        repeat (3) push_sample($urandom, 1'b0);

        write_reg(REG_CHANNELS_IN_USE, 0);
        write_reg(REG_PAD_SHIFT, 0);
        write_reg(REG_FRAMES_PER_PACKET, 8);
        repeat (7) push_sample($urandom, 1'b0);

        write_reg(REG_FRAMES_PER_PACKET, 2);
        repeat (2) push_sample($urandom, 1'b0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 5))
                0, 1, 2: write_reg(REG_CHANNELS_IN_USE, 2);
                3, 4: write_reg(REG_CHANNELS_IN_USE, 4);
                default: write_reg(REG_CHANNELS_IN_USE, $urandom_range(0, 7));
            endcase
            write_reg(REG_PAD_SHIFT, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 31));
            case ($urandom_range(0, 7))
                0: write_reg(REG_COEFF_R, 30000);
                1: write_reg(REG_COEFF_R, 32767);
                2: write_reg(REG_COEFF_R, $urandom_range(0, 32767));
                default: write_reg(REG_COEFF_R, $urandom_range(30000, 32767));
            endcase
            case ($urandom_range(0, 9))
                0: write_reg(REG_FRAMES_PER_PACKET, 0);
                1: write_reg(REG_FRAMES_PER_PACKET, 2047);
                2: write_reg(REG_FRAMES_PER_PACKET, 1024);
                3: write_reg(REG_FRAMES_PER_PACKET, $urandom_range(13, 300));
                default: write_reg(REG_FRAMES_PER_PACKET, $urandom_range(1, 12));
            endcase
            dc_level = $urandom;
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1, 2, 3, 4, 5: raw = dc_level + $urandom_range(0, 8191) - 4096;
                    6, 7: raw = $urandom;
                    8:
                    begin
                        case ($urandom_range(0, 3))
                            0: raw = 32'h7fffffff;
                            1: raw = 32'h80000000;
                            2: raw = 32'h00000000;
                            default: raw = 32'hffffffff;
                        endcase
                    end
                    default: raw = $urandom_range(0, 65535) - 32768;
                endcase
                push_sample(raw, $urandom_range(0, 39) == 0);
            end
            if (phase == 2 || phase == 6)
                holds_requested = holds_requested + 1;
        end

        wait_quiet();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && pcm_expect_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
